/* rtl/core/bmfr_pkg.sv */
// Package for the broadcast message frame receiver: sizes, codes and FSM types.
`default_nettype none

package bmfr_pkg;

  // Frame geometry
  localparam int MESSAGE_LEN  = 32;
  localparam int MAX_MESSAGES = 8;

  localparam int CHR_W = (MESSAGE_LEN > 1) ? $clog2(MESSAGE_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_MESSAGES + 1);

  // Sync sequence and nibble mask
  localparam logic [7:0] SYNC_START  = 8'hF0;
  localparam logic [7:0] SYNC_ONE    = 8'h01;
  localparam logic [7:0] SYNC_TWO    = 8'h03;
  localparam logic [7:0] SYNC_THREE  = 8'h05;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT1,
    PH_WAIT2,
    PH_WAIT3,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_SYNC     = 3'd1,
    ST_BYTE     = 3'd2,
    ST_DONE     = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_TOOBIG   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_COUNT    = 2'd0,
    KIND_INTERVAL = 2'd1,
    KIND_TEXT     = 2'd2
  } kind_t;

endpackage

`default_nettype wire

/* rtl/core/broadcast_message_frame_receiver.sv */
// Broadcast message frame receiver: sync detection and nibble-pair payload decoding.
// Each accepted input byte's result is registered in the single output register.
// Throughput: one byte per cycle; the only limit is the single output register,
// which accepts a new byte whenever it is empty or its result is taken that cycle.
// Reset (rst_n low, synchronous): phase idle, payload counters cleared, output empty.
`default_nettype none

module broadcast_message_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic            out_data_valid,
  output logic [7:0]      out_data_value,
  output logic [1:0]      out_data_kind,
  output logic [2:0]      out_message_index,
  output logic [4:0]      out_char_index
);

  import bmfr_pkg::*;

  // Decoder state
  phase_t           phase_r, phase_nxt;
  logic             odd_r, odd_nxt;          // next byte completes a pair
  kind_t            field_r, field_nxt;      // field the current pair belongs to
  logic [3:0]       high_nibble_r, high_nibble_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;      // decoded message count
  logic [CNT_W-1:0] msg_r, msg_nxt;          // message being received
  logic [CHR_W-1:0] chr_r, chr_nxt;          // character within message

  // Result register
  logic    out_valid_r;
  status_t status_r, status_nxt;
  logic    dvalid_r, dvalid_nxt;
  logic [7:0] value_r, value_nxt;
  kind_t   kind_r, kind_nxt;
  logic [2:0] midx_r, midx_nxt;
  logic [4:0] cidx_r, cidx_nxt;

  logic       accept;
  logic [7:0] pair_value;
  logic       is_sync;
  logic       too_big;
  logic       last_chr;
  logic       last_msg;
  logic [CNT_W+2:0] msg_wide;
  logic [CHR_W+4:0] chr_wide;

  // Hold the input whenever a result is waiting and the far side stalls.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_sync    = (in_rx_byte == SYNC_START);
  assign pair_value = {high_nibble_r, in_rx_byte[3:0] & NIBBLE_MASK};
  assign too_big    = (pair_value > 8'(MAX_MESSAGES));
  assign last_chr   = (chr_r == CHR_W'(MESSAGE_LEN - 1));
  assign last_msg   = ((msg_r + CNT_W'(1)) == count_r);

  // Output positions are reduced to the port widths.
  assign msg_wide = {3'b000, msg_r};
  assign chr_wide = {5'b00000, chr_r};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_sync) begin
      phase_nxt = PH_WAIT1;
    end else begin
      unique case (phase_r)
        PH_WAIT1:   phase_nxt = (in_rx_byte == SYNC_ONE)   ? PH_WAIT2   : PH_IDLE;
        PH_WAIT2:   phase_nxt = (in_rx_byte == SYNC_TWO)   ? PH_WAIT3   : PH_IDLE;
        PH_WAIT3:   phase_nxt = (in_rx_byte == SYNC_THREE) ? PH_PAYLOAD : PH_IDLE;
        PH_PAYLOAD: begin
          if (odd_r) begin
            priority case (field_r)
              KIND_COUNT:    if (too_big) phase_nxt = PH_IDLE;
              KIND_INTERVAL: if (count_r == '0) phase_nxt = PH_IDLE;
              default:       if (last_chr && last_msg) phase_nxt = PH_IDLE;
            endcase
          end
        end
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Result and payload counters
  always_comb begin
    odd_nxt         = odd_r;
    field_nxt       = field_r;
    high_nibble_nxt = high_nibble_r;
    count_nxt       = count_r;
    msg_nxt         = msg_r;
    chr_nxt         = chr_r;
    status_nxt      = ST_NONE;
    dvalid_nxt      = 1'b0;
    value_nxt       = '0;
    kind_nxt        = KIND_COUNT;
    midx_nxt        = '0;
    cidx_nxt        = '0;
    if (is_sync) begin
      status_nxt = ST_SYNC;
    end else begin
      unique case (phase_r)
        PH_WAIT1:   status_nxt = (in_rx_byte == SYNC_ONE) ? ST_SYNC : ST_MISMATCH;
        PH_WAIT2:   status_nxt = (in_rx_byte == SYNC_TWO) ? ST_SYNC : ST_MISMATCH;
        PH_WAIT3: begin
          if (in_rx_byte == SYNC_THREE) begin
            status_nxt      = ST_SYNC;
            odd_nxt         = 1'b0;
            field_nxt       = KIND_COUNT;
            high_nibble_nxt = '0;
            count_nxt       = '0;
            msg_nxt         = '0;
            chr_nxt         = '0;
          end else begin
            status_nxt = ST_MISMATCH;
          end
        end
        PH_PAYLOAD: begin
          if (!odd_r) begin
            // First byte of a pair: keep its low nibble.
            high_nibble_nxt = in_rx_byte[3:0] & NIBBLE_MASK;
            odd_nxt         = 1'b1;
            status_nxt      = ST_BYTE;
          end else begin
            odd_nxt    = 1'b0;
            dvalid_nxt = 1'b1;
            value_nxt  = pair_value;
            kind_nxt   = field_r;
            priority case (field_r)
              KIND_COUNT: begin
                if (too_big) begin
                  status_nxt = ST_TOOBIG;
                end else begin
                  status_nxt = ST_BYTE;
                  count_nxt  = pair_value[CNT_W-1:0];
                  field_nxt  = KIND_INTERVAL;
                end
              end
              KIND_INTERVAL: begin
                status_nxt = (count_r == '0) ? ST_DONE : ST_BYTE;
                field_nxt  = KIND_TEXT;
              end
              default: begin
                status_nxt = (last_chr && last_msg) ? ST_DONE : ST_BYTE;
                midx_nxt   = msg_wide[2:0];
                cidx_nxt   = chr_wide[4:0];
                // Advance the character position, wrapping into the next message.
                if (last_chr) begin
                  chr_nxt = '0;
                  msg_nxt = msg_r + CNT_W'(1);
                end else begin
                  chr_nxt = chr_r + CHR_W'(1);
                end
              end
            endcase
          end
        end
        default:    status_nxt = ST_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      odd_r         <= 1'b0;
      field_r       <= KIND_COUNT;
      high_nibble_r <= '0;
      count_r       <= '0;
      msg_r         <= '0;
      chr_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        odd_r         <= odd_nxt;
        field_r       <= field_nxt;
        high_nibble_r <= high_nibble_nxt;
        count_r       <= count_nxt;
        msg_r         <= msg_nxt;
        chr_r         <= chr_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // Result payload: load on every input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      dvalid_r <= dvalid_nxt;
      value_r  <= value_nxt;
      kind_r   <= kind_nxt;
      midx_r   <= midx_nxt;
      cidx_r   <= cidx_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_data_valid    = dvalid_r;
  assign out_data_value    = value_r;
  assign out_data_kind     = kind_r;
  assign out_message_index = midx_r;
  assign out_char_index    = cidx_r;

  // A frame end or an oversize count always drops the decoder back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status_nxt == ST_DONE || status_nxt == ST_TOOBIG) |=> phase_r == PH_IDLE)
    else $error("decoder not idle after frame end");

  // Decoded data only comes with payload, done or oversize status.
  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |->
      (out_status == ST_BYTE || out_status == ST_DONE || out_status == ST_TOOBIG))
    else $error("data flagged with non-data status");

  // Text positions stay inside the configured frame.
  a_text_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD && field_r == KIND_TEXT |-> msg_r < count_r)
    else $error("text position beyond message count");

endmodule

`default_nettype wire
